/* rtl/dbcq_pkg.sv */
// package: constants, payload structs and state codes for the dirty box queue
`timescale 1ns / 1ps
`default_nettype none
package dbcq_pkg;
  localparam int QUEUE_DEPTH = 64;
  localparam int SPAN_X = 256;
  localparam int SPAN_Y = 128;
  localparam int SPAN_Z = 256;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_APPENDED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  localparam logic CMD_SCHED = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic signed [15:0] lo_x;
    logic signed [15:0] lo_y;
    logic signed [15:0] lo_z;
    logic signed [15:0] hi_x;
    logic signed [15:0] hi_y;
    logic signed [15:0] hi_z;
  } box_t;

  typedef struct packed {
    logic        command;
    logic        light_kind;
    logic signed [15:0] lo_x;
    logic signed [15:0] lo_y;
    logic signed [15:0] lo_z;
    logic signed [15:0] hi_x;
    logic signed [15:0] hi_y;
    logic signed [15:0] hi_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entries_held;
    logic        popped_kind;
    logic signed [15:0] popped_lo_x;
    logic signed [15:0] popped_lo_y;
    logic signed [15:0] popped_lo_z;
    logic signed [15:0] popped_hi_x;
    logic signed [15:0] popped_hi_y;
    logic signed [15:0] popped_hi_z;
    logic [31:0] dropped_total;
    logic [31:0] sky_appended_total;
    logic [31:0] block_appended_total;
  } out_item_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_TEST  = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_DEC   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

/* rtl/dbcq_store.sv */
// box memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module dbcq_store (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [dbcq_pkg::AW-1:0] waddr,
  input  wire dbcq_pkg::box_t        wdata,
  input  wire logic [dbcq_pkg::AW-1:0] raddr,
  output dbcq_pkg::box_t             rdata
);
  import dbcq_pkg::*;
  box_t mem [QUEUE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/dirty_box_coalescing_queue.sv */
// top level: dirty box coalescing queue with sequential head scan
//
// input channel in_valid/in_ready/in_data carries a command item; output
// channel out_valid/out_ready/out_data carries one result per item. the
// queue is a circular buffer in one memory with a head pointer. a pop goes
// from the read state to the output state. a schedule item reads and tests
// held entries from the head one at a time, alternating the read and test
// states; with no match among the held entries it goes to the output state,
// and a match on an entry adds the volume check in states MUL1, MUL2 and DEC
// before output. the volume is formed by one shared multiplier, used in MUL1
// and MUL2. in_ready is high only while idle, from the
// cycle after the result transfer; while out_valid waits on out_ready the
// block holds the result and takes no new item. cfg_we writes
// max_region_volume at once. synchronous reset rst_n clears occupancy, head,
// counters and the register (to 32768); the memory is not cleared and no
// entry is read before it is written.
`timescale 1ns / 1ps
`default_nettype none
module dirty_box_coalescing_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dbcq_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dbcq_pkg::out_item_t        out_data,
  input  wire logic                  cfg_we,
  input  wire logic [23:0]           cfg_data
);
  import dbcq_pkg::*;

  state_t        state_r, state_nxt;
  logic [23:0]   maxv_r;
  logic [CW-1:0] occ_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   drop_r, sky_r, blk_r;
  in_item_t      in_r;
  box_t          nb_r, grown_r;
  logic [AW-1:0] hit_r;
  logic [47:0]   vol_r;
  logic          neg_r;
  box_t          rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  function automatic logic signed [15:0] clo(input logic signed [15:0] lo,
                                              input logic signed [15:0] hi, input int span);
    logic signed [15:0] l, h;
    l = (lo < 0) ? 16'sd0 : lo;
    h = (hi >= 16'(span)) ? 16'(span - 1) : hi;
    return (l > h) ? h : l;
  endfunction
  function automatic logic signed [15:0] chi(input logic signed [15:0] hi, input int span);
    return (hi >= 16'(span)) ? 16'(span - 1) : hi;
  endfunction
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, i};
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction
  function automatic logic fits(input logic signed [15:0] rl, input logic signed [15:0] rh,
                                input logic signed [15:0] bl, input logic signed [15:0] bh);
    return !(17'(rl) < 17'(bl) - 17'sd1) && !(17'(rh) > 17'(bh) + 17'sd1);
  endfunction

  box_t nb_c, gr_c;
  logic hit_c;
  logic [2:0] rd_st_c;
  always_comb begin
    nb_c.kind = in_r.light_kind;
    nb_c.lo_x = clo(in_r.lo_x, in_r.hi_x, SPAN_X);
    nb_c.lo_y = clo(in_r.lo_y, in_r.hi_y, SPAN_Y);
    nb_c.lo_z = clo(in_r.lo_z, in_r.hi_z, SPAN_Z);
    nb_c.hi_x = chi(in_r.hi_x, SPAN_X);
    nb_c.hi_y = chi(in_r.hi_y, SPAN_Y);
    nb_c.hi_z = chi(in_r.hi_z, SPAN_Z);
    hit_c = (rdata.kind == in_r.light_kind) &&
            fits(in_r.lo_x, in_r.hi_x, rdata.lo_x, rdata.hi_x) &&
            fits(in_r.lo_y, in_r.hi_y, rdata.lo_y, rdata.hi_y) &&
            fits(in_r.lo_z, in_r.hi_z, rdata.lo_z, rdata.hi_z);
    gr_c.kind = rdata.kind;
    gr_c.lo_x = (nb_r.lo_x < rdata.lo_x) ? nb_r.lo_x : rdata.lo_x;
    gr_c.lo_y = (nb_r.lo_y < rdata.lo_y) ? nb_r.lo_y : rdata.lo_y;
    gr_c.lo_z = (nb_r.lo_z < rdata.lo_z) ? nb_r.lo_z : rdata.lo_z;
    gr_c.hi_x = (nb_r.hi_x > rdata.hi_x) ? nb_r.hi_x : rdata.hi_x;
    gr_c.hi_y = (nb_r.hi_y > rdata.hi_y) ? nb_r.hi_y : rdata.hi_y;
    gr_c.hi_z = (nb_r.hi_z > rdata.hi_z) ? nb_r.hi_z : rdata.hi_z;
    rd_st_c = ST_APPENDED;
    if (in_r.command == CMD_POP) rd_st_c = (occ_r == '0) ? ST_EMPTY : ST_POPPED;
  end

  // shared multiplier: extents of grown box
  logic signed [17:0] ex, ey, ez;
  logic [47:0] mul_a, mul_p;
  logic [16:0] mul_b;
  always_comb begin
    ex = 18'(grown_r.hi_x) - 18'(grown_r.lo_x) + 18'sd1;
    ey = 18'(grown_r.hi_y) - 18'(grown_r.lo_y) + 18'sd1;
    ez = 18'(grown_r.hi_z) - 18'(grown_r.lo_z) + 18'sd1;
    mul_a = (state_r == S_MUL1) ? 48'(ex[16:0]) : vol_r;
    mul_b = (state_r == S_MUL1) ? ey[16:0] : ez[16:0];
    mul_p = 48'(mul_a[33:0]) * 48'(mul_b);
  end

  assign raddr = wrap(head_r, idx_r);
  dbcq_store u_store (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                      .raddr(raddr), .rdata(rdata));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    waddr = hit_r;
    wdata = grown_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: begin
        if (in_r.command == CMD_POP) state_nxt = S_OUT;
        else if (idx_r >= occ_r) state_nxt = S_OUT;
        else state_nxt = S_TEST;
      end
      S_TEST: state_nxt = hit_c ? S_MUL1 : S_READ;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DEC;
      S_DEC: begin
        we = 1'b1;
        wdata = (neg_r || vol_r > 48'(maxv_r)) ? nb_r : grown_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_valid && out_ready) state_nxt = S_IDLE;
        if (!out_valid && in_r.command == CMD_SCHED && idx_r >= occ_r &&
            occ_r < CW'(QUEUE_DEPTH) && out_data.status == ST_APPENDED) begin
          we = 1'b1;
          waddr = wrap(head_r, occ_r);
          wdata = nb_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      maxv_r <= 24'd32768;
      occ_r <= '0;
      head_r <= '0;
      drop_r <= '0;
      sky_r <= '0;
      blk_r <= '0;
      out_valid <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) maxv_r <= cfg_data;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          in_r <= in_data;
          idx_r <= '0;
        end
        S_READ: begin
          nb_r <= nb_c;
          out_data <= {rd_st_c, {($bits(out_item_t) - 3){1'b0}}};
        end
        S_TEST: begin
          grown_r <= gr_c;
          hit_r <= raddr;
          if (!hit_c) idx_r <= idx_r + 1'b1;
        end
        S_MUL1: begin
          vol_r <= mul_p;
          neg_r <= ex[17] || ey[17] || ez[17];
        end
        S_MUL2: begin
          vol_r <= mul_p;
          neg_r <= neg_r || ez[17];
        end
        S_DEC: out_data.status <= (neg_r || vol_r > 48'(maxv_r)) ? ST_REPLACED : ST_MERGED;
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (in_r.command == CMD_POP) begin
              if (occ_r != '0) begin
                out_data.popped_kind <= rdata.kind;
                out_data.popped_lo_x <= rdata.lo_x;
                out_data.popped_lo_y <= rdata.lo_y;
                out_data.popped_lo_z <= rdata.lo_z;
                out_data.popped_hi_x <= rdata.hi_x;
                out_data.popped_hi_y <= rdata.hi_y;
                out_data.popped_hi_z <= rdata.hi_z;
                occ_r <= occ_r - 1'b1;
                head_r <= wrap(head_r, CW'(1));
                out_data.entries_held <= 7'(occ_r - 1'b1);
              end else out_data.entries_held <= 7'(occ_r);
              out_data.dropped_total <= drop_r;
              out_data.sky_appended_total <= sky_r;
              out_data.block_appended_total <= blk_r;
            end else if (out_data.status == ST_APPENDED) begin
              if (occ_r >= CW'(QUEUE_DEPTH)) begin
                out_data.status <= ST_DROPPED;
                drop_r <= drop_r + 1'b1;
                out_data.dropped_total <= drop_r + 1'b1;
                out_data.sky_appended_total <= sky_r;
                out_data.block_appended_total <= blk_r;
                out_data.entries_held <= 7'(occ_r);
              end else begin
                occ_r <= occ_r + 1'b1;
                out_data.entries_held <= 7'(occ_r + 1'b1);
                out_data.dropped_total <= drop_r;
                if (nb_r.kind) begin
                  sky_r <= sky_r + 1'b1;
                  out_data.sky_appended_total <= sky_r + 1'b1;
                  out_data.block_appended_total <= blk_r;
                end else begin
                  blk_r <= blk_r + 1'b1;
                  out_data.block_appended_total <= blk_r + 1'b1;
                  out_data.sky_appended_total <= sky_r;
                end
              end
            end else begin
              out_data.entries_held <= 7'(occ_r);
              out_data.dropped_total <= drop_r;
              out_data.sky_appended_total <= sky_r;
              out_data.block_appended_total <= blk_r;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/dbcq_checker.sv */
// port-level checker for the dirty box queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dbcq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dbcq_pkg::out_item_t out_data
);
  import dbcq_pkg::*;
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_EMPTY) else $error("bad status");
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_POPPED |-> out_data.popped_kind == 1'b0)
    else $error("popped kind without pop");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");
endmodule

bind dirty_box_coalescing_queue dbcq_checker u_dbcq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
`default_nettype wire

/* sim/testbench.sv */
// testbench for the dirty box coalescing queue: directed table, random traffic, predictor check
`timescale 1ns / 1ps
module testbench;
  import dbcq_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IN_W = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;

  dirty_box_coalescing_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  box_t queue_boxes[$];
  logic [31:0] drops_pred, sky_pred, block_pred;
  logic [23:0] volume_limit;
  out_item_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int status_seen[8];
  bit sender_done = 1'b0;

  function automatic longint span_of(int k);
    return (k == 1) ? SPAN_Y : ((k == 0) ? SPAN_X : SPAN_Z);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    box_t nb, b;
    int rlo[3], rhi[3], clo[3], chi[3], blo[3], bhi[3];
    bit hit;
    longint vol;
    r = '0;
    if (it.command == CMD_POP) begin
      if (queue_boxes.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        b = queue_boxes.pop_front();
        r.status = ST_POPPED;
        r.popped_kind = b.kind;
        r.popped_lo_x = b.lo_x; r.popped_lo_y = b.lo_y; r.popped_lo_z = b.lo_z;
        r.popped_hi_x = b.hi_x; r.popped_hi_y = b.hi_y; r.popped_hi_z = b.hi_z;
      end
    end else begin
      rlo = '{int'(it.lo_x), int'(it.lo_y), int'(it.lo_z)};
      rhi = '{int'(it.hi_x), int'(it.hi_y), int'(it.hi_z)};
      for (int k = 0; k < 3; k++) begin
        clo[k] = rlo[k] < 0 ? 0 : rlo[k];
        chi[k] = rhi[k] >= span_of(k) ? int'(span_of(k)) - 1 : rhi[k];
        if (clo[k] > chi[k]) clo[k] = chi[k];
      end
      nb.kind = it.light_kind;
      nb.lo_x = 16'(clo[0]); nb.lo_y = 16'(clo[1]); nb.lo_z = 16'(clo[2]);
      nb.hi_x = 16'(chi[0]); nb.hi_y = 16'(chi[1]); nb.hi_z = 16'(chi[2]);
      hit = 1'b0;
      foreach (queue_boxes[i]) begin
        b = queue_boxes[i];
        if (!hit && b.kind == it.light_kind) begin
          blo = '{int'(b.lo_x), int'(b.lo_y), int'(b.lo_z)};
          bhi = '{int'(b.hi_x), int'(b.hi_y), int'(b.hi_z)};
          if (rlo[0] >= blo[0] - 1 && rhi[0] <= bhi[0] + 1 &&
              rlo[1] >= blo[1] - 1 && rhi[1] <= bhi[1] + 1 &&
              rlo[2] >= blo[2] - 1 && rhi[2] <= bhi[2] + 1) begin
            hit = 1'b1;
            vol = 1;
            for (int k = 0; k < 3; k++) begin
              if (clo[k] < blo[k]) blo[k] = clo[k];
              if (chi[k] > bhi[k]) bhi[k] = chi[k];
              vol = vol * (longint'(bhi[k]) - blo[k] + 1);
            end
            if (vol > longint'(volume_limit)) begin
              queue_boxes[i] = nb;
              r.status = ST_REPLACED;
            end else begin
              b.lo_x = 16'(blo[0]); b.lo_y = 16'(blo[1]); b.lo_z = 16'(blo[2]);
              b.hi_x = 16'(bhi[0]); b.hi_y = 16'(bhi[1]); b.hi_z = 16'(bhi[2]);
              queue_boxes[i] = b;
              r.status = ST_MERGED;
            end
          end
        end
      end
      if (!hit) begin
        if (queue_boxes.size() >= QUEUE_DEPTH) begin
          drops_pred++;
          r.status = ST_DROPPED;
        end else begin
          queue_boxes.push_back(nb);
          if (it.light_kind) sky_pred++;
          else block_pred++;
          r.status = ST_APPENDED;
        end
      end
    end
    r.entries_held = 7'(queue_boxes.size());
    r.dropped_total = drops_pred;
    r.sky_appended_total = sky_pred;
    r.block_appended_total = block_pred;
    return r;
  endfunction

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, compare on transfer
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      transfers_out++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation, status %0d", out_data.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        status_seen[out_data.status]++;
        report_field("status", want.status, out_data.status);
        report_field("entries_held", want.entries_held, out_data.entries_held);
        report_field("popped_kind", want.popped_kind, out_data.popped_kind);
        report_field("popped_lo_x", want.popped_lo_x, out_data.popped_lo_x);
        report_field("popped_lo_y", want.popped_lo_y, out_data.popped_lo_y);
        report_field("popped_lo_z", want.popped_lo_z, out_data.popped_lo_z);
        report_field("popped_hi_x", want.popped_hi_x, out_data.popped_hi_x);
        report_field("popped_hi_y", want.popped_hi_y, out_data.popped_hi_y);
        report_field("popped_hi_z", want.popped_hi_z, out_data.popped_hi_z);
        report_field("dropped_total", want.dropped_total, out_data.dropped_total);
        report_field("sky_appended_total", want.sky_appended_total,
                     out_data.sky_appended_total);
        report_field("block_appended_total", want.block_appended_total,
                     out_data.block_appended_total);
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (sender_done || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    end
  end

  // send one item, expectation built when the transfer happens
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(2, 4)) : 1;
    repeat (gap) @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(it));
    transfers_in++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // directed row with optional typed-in expectation
  task automatic send_checked(in_item_t it, bit known, logic [2:0] st, int held);
    out_item_t got;
    send_item(it);
    got = pending_results[$];
    if (known) begin
      report_field("status", st, got.status);
      report_field("entries_held", held, got.entries_held);
    end
  endtask

  task automatic drain_all();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    drain_all();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    volume_limit = v;
  endtask

  function automatic in_item_t make_box(logic cmd, logic kind, int lx, int ly, int lz,
                                        int hx, int hy, int hz);
    in_item_t it;
    it.command = cmd; it.light_kind = kind;
    it.lo_x = 16'(lx); it.lo_y = 16'(ly); it.lo_z = 16'(lz);
    it.hi_x = 16'(hx); it.hi_y = 16'(hy); it.hi_z = 16'(hz);
    return it;
  endfunction

  function automatic in_item_t random_item(int spread);
    in_item_t it;
    int a, w;
    it = '0;
    if ($urandom_range(0, 9) == 0) begin
      it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
      return it;
    end
    it.command = ($urandom_range(0, 99) < 30) ? CMD_POP : CMD_SCHED;
    it.light_kind = 1'($urandom_range(0, 1));
    a = $urandom_range(0, spread) - 4; w = $urandom_range(0, 6) - 1;
    it.lo_x = 16'(a); it.hi_x = 16'(a + w);
    a = $urandom_range(0, spread / 2) - 4; w = $urandom_range(0, 6) - 1;
    it.lo_y = 16'(a); it.hi_y = 16'(a + w);
    a = $urandom_range(0, spread) - 4; w = $urandom_range(0, 6) - 1;
    it.lo_z = 16'(a); it.hi_z = 16'(a + w);
    return it;
  endfunction

  typedef struct {
    in_item_t item;
    bit known;
    logic [2:0] st;
    int held;
  } row_t;

  row_t rows[$];

  initial begin
    drops_pred = '0; sky_pred = '0; block_pred = '0;
    volume_limit = 24'd32768;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back(row_t'{make_box(CMD_POP, 1'b0, 0, 0, 0, 0, 0, 0), 1'b1, ST_EMPTY, 0});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b0, 0, 0, 0, 0, 0, 0), 1'b1, ST_APPENDED, 1});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b0, 1, 1, 1, 1, 1, 1), 1'b1, ST_MERGED, 1});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b1, 1, 1, 1, 1, 1, 1), 1'b1, ST_APPENDED, 2});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b0, -32768, -32768, -32768,
                                   32767, 32767, 32767), 1'b1, ST_APPENDED, 3});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b1, -5, -5, -5, -3, -3, -3),
                          1'b1, ST_APPENDED, 4});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b1, -6, -6, -6, -2, -2, -2),
                          1'b0, ST_MERGED, 0});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b0, 300, 200, 300, 100, 50, 100),
                          1'b0, ST_MERGED, 0});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b0, -1, -1, -1, 2, 2, 2), 1'b0, ST_MERGED, 0});
    rows.push_back(row_t'{make_box(CMD_SCHED, 1'b1, 32767, 32767, 32767,
                                   -32768, -32768, -32768), 1'b0, ST_MERGED, 0});
    rows.push_back(row_t'{make_box(CMD_POP, 1'b1, 0, 0, 0, 0, 0, 0), 1'b0, ST_MERGED, 0});
    rows.push_back(row_t'{make_box(CMD_POP, 1'b0, 0, 0, 0, 0, 0, 0), 1'b0, ST_MERGED, 0});
    foreach (rows[i]) send_checked(rows[i].item, rows[i].known, rows[i].st, rows[i].held);

    // fill to overflow with disjoint boxes
    write_limit(24'd1);
    for (int i = 0; i < 70; i++)
      send_item(make_box(CMD_SCHED, i[0], (i % 8) * 30, (i / 8) * 14, 5, (i % 8) * 30 + 2,
                         (i / 8) * 14 + 2, 6));
    send_item(make_box(CMD_SCHED, 1'b0, 0, 0, 5, 3, 2, 6));
    for (int i = 0; i < 66; i++) send_item(make_box(CMD_POP, 1'b0, 0, 0, 0, 0, 0, 0));

    write_limit(24'd0);
    for (int i = 0; i < 40; i++) send_item(random_item(12));
    write_limit(24'hFFFFFF);
    for (int i = 0; i < 60; i++) send_item(random_item(12));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 400 == 399) begin
        case ($urandom_range(0, 3))
          0: write_limit(24'd1);
          1: write_limit(24'd8388608);
          2: write_limit(24'd32768);
          default: write_limit(24'($urandom_range(1, 2000)));
        endcase
      end
      if (i == 900) drain_all();
      send_item(random_item((i % 300 < 150) ? 20 : 300));
    end

    drain_all();
    sender_done = 1'b1;
    $display("covered %0d input transfers and %0d result transfers", transfers_in, transfers_out);
    $display("statuses: merged %0d replaced %0d appended %0d dropped %0d popped %0d empty %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end
endmodule
